// File: rtl/core/qrs_pkg.sv
package qrs_pkg;

  // Square root: 50-bit radicand, one result bit per stage.
  localparam int SqrtBits = 25;
  localparam int RadBits  = 2 * SqrtBits;
  localparam int RemBits  = SqrtBits + 3;

  // Divider: 32-bit dividend magnitude over a 16-bit divisor magnitude.
  localparam int DivBits  = 32;
  localparam int DvsBits  = 16;

  // Sideband that rides along the square root pipeline.
  typedef struct packed {
    logic               bad;
    logic               cplx;
    logic signed [33:0] disc;
    logic signed [15:0] a;
    logic signed [15:0] b;
  } sq_side_t;

  // Sideband that rides along the divider pipeline.
  typedef struct packed {
    logic               bad;
    logic               cplx;
    logic signed [33:0] disc;
    logic               neg1;
    logic               neg2;
  } dv_side_t;

  // Apply the sign to a quotient magnitude and saturate to 32 signed bits.
  function automatic logic signed [31:0] sat_signed(input logic [DivBits-1:0] mag,
                                                   input logic neg);
    logic signed [31:0] res;
    if (neg) begin
      if (mag > 32'h8000_0000) begin
        res = 32'sh8000_0000;
      end else begin
        res = -$signed(mag);
      end
    end else begin
      if (mag[DivBits-1]) begin
        res = 32'sh7fff_ffff;
      end else begin
        res = $signed(mag);
      end
    end
    return res;
  endfunction

endpackage

// File: rtl/core/qrs_if.sv
// Coefficient channel.
interface qrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] coef_a;
  logic signed [15:0] coef_b;
  logic signed [15:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

// Root channel.
interface qrs_out_if;
  logic               valid;
  logic               ready;
  logic               bad_leading;
  logic               is_complex;
  logic signed [33:0] discriminant;
  logic signed [31:0] root1_real;
  logic signed [31:0] root1_imag;
  logic signed [31:0] root2_real;
  logic signed [31:0] root2_imag;

  modport source (output valid, bad_leading, is_complex, discriminant, root1_real,
                  root1_imag, root2_real, root2_imag, input ready);
  modport sink   (input valid, bad_leading, is_complex, discriminant, root1_real,
                  root1_imag, root2_real, root2_imag, output ready);
endinterface

// File: rtl/core/qrs_sqrt.sv
// Pipelined integer square root, one result bit resolved per stage.
module qrs_sqrt import qrs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [RadBits-1:0]  rad_i,
  input  sq_side_t            side_i,
  output logic                valid_o,
  output logic [SqrtBits-1:0] root_o,
  output sq_side_t            side_o
);

  logic                v_q    [SqrtBits];
  logic [RadBits-1:0]  rad_q  [SqrtBits];
  logic [RemBits-1:0]  rem_q  [SqrtBits];
  logic [SqrtBits-1:0] root_q [SqrtBits];
  sq_side_t            side_q [SqrtBits];

  logic                v_d    [SqrtBits];
  logic [RadBits-1:0]  rad_d  [SqrtBits];
  logic [RemBits-1:0]  rem_d  [SqrtBits];
  logic [SqrtBits-1:0] root_d [SqrtBits];
  sq_side_t            side_d [SqrtBits];

  // Each stage brings down two radicand bits and tries the next root bit.
  always_comb begin
    logic                iv;
    logic [RadBits-1:0]  irad;
    logic [RemBits-1:0]  irem;
    logic [SqrtBits-1:0] iroot;
    sq_side_t            iside;
    logic [RemBits-1:0]  cur;
    logic [RemBits-1:0]  trial;
    logic                ge;
    for (int k = 0; k < SqrtBits; k++) begin
      if (k == 0) begin
        iv    = valid_i;
        irad  = rad_i;
        irem  = '0;
        iroot = '0;
        iside = side_i;
      end else begin
        iv    = v_q[k-1];
        irad  = rad_q[k-1];
        irem  = rem_q[k-1];
        iroot = root_q[k-1];
        iside = side_q[k-1];
      end
      cur   = {irem[RemBits-3:0], irad[RadBits-1 -: 2]};
      trial = {1'b0, iroot, 2'b01};
      ge    = (cur >= trial);
      v_d[k]    = iv;
      rad_d[k]  = {irad[RadBits-3:0], 2'b00};
      rem_d[k]  = ge ? (cur - trial) : cur;
      root_d[k] = {iroot[SqrtBits-2:0], ge};
      side_d[k] = iside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SqrtBits; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < SqrtBits; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < SqrtBits; k++) begin
        rad_q[k]  <= rad_d[k];
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = v_q[SqrtBits-1];
  assign root_o  = root_q[SqrtBits-1];
  assign side_o  = side_q[SqrtBits-1];

endmodule

// File: rtl/core/qrs_div.sv
// Two-lane pipelined restoring divider sharing one divisor, one quotient
// bit per stage.
module qrs_div import qrs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [DivBits-1:0] num1_i,
  input  logic [DivBits-1:0] num2_i,
  input  logic [DvsBits-1:0] dvs_i,
  input  dv_side_t           side_i,
  output logic               valid_o,
  output logic [DivBits-1:0] quo1_o,
  output logic [DivBits-1:0] quo2_o,
  output dv_side_t           side_o
);

  logic               v_q    [DivBits];
  logic [DivBits-1:0] num1_q [DivBits];
  logic [DivBits-1:0] num2_q [DivBits];
  logic [DvsBits-1:0] rem1_q [DivBits];
  logic [DvsBits-1:0] rem2_q [DivBits];
  logic [DivBits-1:0] quo1_q [DivBits];
  logic [DivBits-1:0] quo2_q [DivBits];
  logic [DvsBits-1:0] dvs_q  [DivBits];
  dv_side_t           side_q [DivBits];

  logic               v_d    [DivBits];
  logic [DivBits-1:0] num1_d [DivBits];
  logic [DivBits-1:0] num2_d [DivBits];
  logic [DvsBits-1:0] rem1_d [DivBits];
  logic [DvsBits-1:0] rem2_d [DivBits];
  logic [DivBits-1:0] quo1_d [DivBits];
  logic [DivBits-1:0] quo2_d [DivBits];
  logic [DvsBits-1:0] dvs_d  [DivBits];
  dv_side_t           side_d [DivBits];

  // Each stage shifts in one dividend bit and subtracts when it fits.
  always_comb begin
    logic               iv;
    logic [DivBits-1:0] in1, in2, iq1, iq2;
    logic [DvsBits-1:0] ir1, ir2, idv;
    dv_side_t           iside;
    logic [DvsBits:0]   cur1, cur2, dext;
    logic               ge1, ge2;
    for (int k = 0; k < DivBits; k++) begin
      if (k == 0) begin
        iv = valid_i; in1 = num1_i; in2 = num2_i; ir1 = '0; ir2 = '0;
        iq1 = '0; iq2 = '0; idv = dvs_i; iside = side_i;
      end else begin
        iv = v_q[k-1]; in1 = num1_q[k-1]; in2 = num2_q[k-1];
        ir1 = rem1_q[k-1]; ir2 = rem2_q[k-1];
        iq1 = quo1_q[k-1]; iq2 = quo2_q[k-1];
        idv = dvs_q[k-1]; iside = side_q[k-1];
      end
      dext = {1'b0, idv};
      cur1 = {ir1, in1[DivBits-1]};
      cur2 = {ir2, in2[DivBits-1]};
      ge1  = (cur1 >= dext);
      ge2  = (cur2 >= dext);
      v_d[k]    = iv;
      num1_d[k] = {in1[DivBits-2:0], 1'b0};
      num2_d[k] = {in2[DivBits-2:0], 1'b0};
      rem1_d[k] = ge1 ? DvsBits'(cur1 - dext) : cur1[DvsBits-1:0];
      rem2_d[k] = ge2 ? DvsBits'(cur2 - dext) : cur2[DvsBits-1:0];
      quo1_d[k] = {iq1[DivBits-2:0], ge1};
      quo2_d[k] = {iq2[DivBits-2:0], ge2};
      dvs_d[k]  = idv;
      side_d[k] = iside;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DivBits; k++) v_q[k] <= 1'b0;
    end else if (en_i) begin
      for (int k = 0; k < DivBits; k++) v_q[k] <= v_d[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DivBits; k++) begin
        num1_q[k] <= num1_d[k];
        num2_q[k] <= num2_d[k];
        rem1_q[k] <= rem1_d[k];
        rem2_q[k] <= rem2_d[k];
        quo1_q[k] <= quo1_d[k];
        quo2_q[k] <= quo2_d[k];
        dvs_q[k]  <= dvs_d[k];
        side_q[k] <= side_d[k];
      end
    end
  end

  assign valid_o = v_q[DivBits-1];
  assign quo1_o  = quo1_q[DivBits-1];
  assign quo2_o  = quo2_q[DivBits-1];
  assign side_o  = side_q[DivBits-1];

endmodule

// File: rtl/core/quadratic_root_solver.sv
// Quadratic root solver. Each item carries signed Q8.8 coefficients a, b, c
// and yields the exact Q16.16 discriminant and both roots in saturated
// Q16.16, real or as a complex pair. One item is taken every cycle while the
// output is not stalled; the pipeline is an input register, the discriminant
// multiply, 25 square root stages, the numerator stage, 32 divider stages and
// the output register. The whole pipeline holds while a finished item waits at
// the output, so nothing is lost or repeated under back pressure.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  qrs_in_if.sink     in_i,
  qrs_out_if.source  out_o
);

  logic en;

  // Input register.
  logic               v0_q;
  logic signed [15:0] a0_q, b0_q, c0_q;

  // Discriminant register.
  logic               v1_q;
  logic signed [33:0] disc1_q;
  logic signed [15:0] a1_q, b1_q;
  logic signed [31:0] bb, ac;
  logic signed [33:0] disc1_d;

  // Square root signals.
  logic [33:0]         dmag;
  logic [RadBits-1:0]  rad;
  sq_side_t            sq_in, sq_out;
  logic                sq_v;
  logic [SqrtBits-1:0] sroot;

  // Numerator register.
  logic               v2_q;
  dv_side_t           side2_q, side2_d;
  logic [DivBits-1:0] num1_q, num2_q, num1_d, num2_d;
  logic [DvsBits-1:0] dvs_q, dvs_d;

  // Divider outputs.
  logic               dv_v;
  logic [DivBits-1:0] quo1, quo2;
  dv_side_t           dv_side;

  // Output register.
  logic               ov_q;
  logic               bad_q, cplx_q;
  logic signed [33:0] disc_q;
  logic signed [31:0] r1r_q, r1i_q, r2r_q, r2i_q;
  logic signed [31:0] r1r_d, r1i_d, r2r_d, r2i_d;

  // The pipeline moves unless the output holds an item not yet taken.
  assign en         = !ov_q || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      ov_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= sq_v;
      ov_q <= dv_v;
    end
  end

  // Exact discriminant b*b - 4ac.
  assign bb      = b0_q * b0_q;
  assign ac      = a0_q * c0_q;
  assign disc1_d = {{2{bb[31]}}, bb} - {ac, 2'b00};

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q    <= in_i.coef_a;
      b0_q    <= in_i.coef_b;
      c0_q    <= in_i.coef_c;
      disc1_q <= disc1_d;
      a1_q    <= a0_q;
      b1_q    <= b0_q;
    end
  end

  // The root is taken of |D| scaled by 2^16.
  assign dmag  = disc1_q[33] ? 34'(-disc1_q) : disc1_q;
  assign rad   = {dmag, 16'h0000};
  assign sq_in = '{bad: (a1_q == 16'sd0), cplx: disc1_q[33], disc: disc1_q,
                   a: a1_q, b: b1_q};

  qrs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .rad_i   (rad),
    .side_i  (sq_in),
    .valid_o (sq_v),
    .root_o  (sroot),
    .side_o  (sq_out)
  );

  // Dividend magnitudes and quotient signs for both cases.
  always_comb begin
    logic signed [26:0] nb, np, nm;
    logic [26:0]        mp, mm;
    logic [15:0]        bmag;
    nb   = -({{3{sq_out.b[15]}}, sq_out.b, 8'h00});
    np   = nb + $signed({2'b00, sroot});
    nm   = nb - $signed({2'b00, sroot});
    mp   = np[26] ? 27'(-np) : np;
    mm   = nm[26] ? 27'(-nm) : nm;
    bmag = sq_out.b[15] ? 16'(-sq_out.b) : sq_out.b;
    dvs_d = sq_out.a[15] ? 16'(-sq_out.a) : sq_out.a;
    side2_d.bad  = sq_out.bad;
    side2_d.cplx = sq_out.cplx;
    side2_d.disc = sq_out.disc;
    if (sq_out.cplx) begin
      num1_d       = {1'b0, bmag, 15'h0000};
      num2_d       = {sroot, 7'h00};
      side2_d.neg1 = !sq_out.b[15] ^ sq_out.a[15];
      side2_d.neg2 = 1'b0;
    end else begin
      num1_d       = {mp[24:0], 7'h00};
      num2_d       = {mm[24:0], 7'h00};
      side2_d.neg1 = np[26] ^ sq_out.a[15];
      side2_d.neg2 = nm[26] ^ sq_out.a[15];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side2_q <= side2_d;
      num1_q  <= num1_d;
      num2_q  <= num2_d;
      dvs_q   <= dvs_d;
    end
  end

  qrs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num1_i  (num1_q),
    .num2_i  (num2_q),
    .dvs_i   (dvs_q),
    .side_i  (side2_q),
    .valid_o (dv_v),
    .quo1_o  (quo1),
    .quo2_o  (quo2),
    .side_o  (dv_side)
  );

  // Signs, saturation and the zero leading coefficient case.
  always_comb begin
    r1r_d = sat_signed(quo1, dv_side.neg1);
    if (dv_side.cplx) begin
      r2r_d = r1r_d;
      r1i_d = sat_signed(quo2, 1'b0);
      r2i_d = sat_signed(quo2, 1'b1);
    end else begin
      r2r_d = sat_signed(quo2, dv_side.neg2);
      r1i_d = '0;
      r2i_d = '0;
    end
    if (dv_side.bad) begin
      r1r_d = '0;
      r1i_d = '0;
      r2r_d = '0;
      r2i_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bad_q  <= dv_side.bad;
      cplx_q <= dv_side.cplx;
      disc_q <= dv_side.disc;
      r1r_q  <= r1r_d;
      r1i_q  <= r1i_d;
      r2r_q  <= r2r_d;
      r2i_q  <= r2i_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.bad_leading  = bad_q;
  assign out_o.is_complex   = cplx_q;
  assign out_o.discriminant = disc_q;
  assign out_o.root1_real   = r1r_q;
  assign out_o.root1_imag   = r1i_q;
  assign out_o.root2_real   = r2r_q;
  assign out_o.root2_imag   = r2i_q;

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import qrs_pkg::*;

  // Expected contents of one root item.
  typedef struct {
    logic               bad;
    logic               cplx;
    logic signed [33:0] disc;
    logic signed [31:0] r1_re;
    logic signed [31:0] r1_im;
    logic signed [31:0] r2_re;
    logic signed [31:0] r2_im;
  } roots_t;

  localparam int StallLimit = 3000;

  logic clk;
  logic rst_n;
  qrs_in_if  in_if ();
  qrs_out_if out_if ();

  roots_t roots_q[$];
  int     err_cnt;
  int     idle_cnt;
  int     hold_cycles;
  bit     steady;

  quadratic_root_solver uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Floored integer square root by the bitwise method.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Clamp to the signed 32-bit range.
  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Roots of one coefficient set.
  function automatic roots_t solve_roots(input logic signed [15:0] a,
                                         input logic signed [15:0] b,
                                         input logic signed [15:0] c);
    roots_t r;
    longint ai, bi, ci, d, s, aa, im;
    longint r1r, r1i, r2r, r2i;
    longint unsigned mag;
    ai = a;
    bi = b;
    ci = c;
    d  = bi * bi - 4 * ai * ci;
    r1r = 0;
    r1i = 0;
    r2r = 0;
    r2i = 0;
    if (ai != 0) begin
      mag = (d < 0) ? -d : d;
      s   = floor_sqrt(mag << 16);
      if (d >= 0) begin
        r1r = ((-bi * 256 + s) * 128) / ai;
        r2r = ((-bi * 256 - s) * 128) / ai;
      end else begin
        aa  = (ai < 0) ? -ai : ai;
        im  = (s * 128) / aa;
        r1r = (-bi * 32768) / ai;
        r2r = r1r;
        r1i = im;
        r2i = -im;
      end
    end
    r.bad   = (ai == 0);
    r.cplx  = (d < 0);
    r.disc  = d[33:0];
    r.r1_re = clamp32(r1r);
    r.r1_im = clamp32(r1i);
    r.r2_re = clamp32(r2r);
    r.r2_im = clamp32(r2i);
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    err_cnt++;
  endtask

  // Send one coefficient item, with random idle cycles ahead of it unless steady is set.
  task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c);
    while (!steady && $urandom_range(99) < 8) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid  = 1'b1;
    in_if.coef_a = a;
    in_if.coef_b = b;
    in_if.coef_c = c;
    do @(posedge clk); while (!in_if.ready);
    roots_q.push_back(solve_roots(a, b, c));
    @(negedge clk);
  endtask

  // Receiver: random stalls (always ready while steady), or a counted hold-off when asked.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles  <= hold_cycles - 1;
    end else begin
      out_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 8);
    end
  end

  // Compare each root item with the oldest expectation.
  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (roots_q.size() == 0) begin
        $display("root item with nothing expected");
        err_cnt++;
      end else begin
        e = roots_q.pop_front();
        if (out_if.bad_leading !== e.bad) report("bad_leading", out_if.bad_leading, e.bad);
        if (out_if.is_complex !== e.cplx) report("is_complex", out_if.is_complex, e.cplx);
        if (out_if.discriminant !== e.disc) report("discriminant", out_if.discriminant, e.disc);
        if (out_if.root1_real !== e.r1_re) report("root1_real", out_if.root1_real, e.r1_re);
        if (out_if.root1_imag !== e.r1_im) report("root1_imag", out_if.root1_imag, e.r1_im);
        if (out_if.root2_real !== e.r2_re) report("root2_real", out_if.root2_real, e.r2_re);
        if (out_if.root2_imag !== e.r2_im) report("root2_imag", out_if.root2_imag, e.r2_im);
      end
    end
  end

  // Watchdog on cycles where no item moves on either side.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Extremes, zero leading coefficient, complex, repeated and saturated roots.
  task automatic test_directed();
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0000, 16'h8000, 16'h7fff);
    send_coefs(16'h0000, 16'h7fff, 16'h8000);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h7fff, 16'h8000, 16'h8000);
    send_coefs(16'h8000, 16'h0000, 16'h8000);
    send_coefs(16'h0100, 16'h0000, 16'hff00);
    send_coefs(16'h0100, 16'h0000, 16'h0100);
    send_coefs(16'h0100, 16'h0200, 16'h0100);
    send_coefs(16'hff00, 16'h0400, 16'hfc00);
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'h0001, 16'h7fff, 16'h0000);
    send_coefs(16'hffff, 16'h7fff, 16'h7fff);
    send_coefs(16'h0001, 16'h0000, 16'h7fff);
    send_coefs(16'hffff, 16'h8000, 16'h8000);
    send_coefs(16'h0001, 16'h0001, 16'h0001);
    send_coefs(16'h0300, 16'hfb00, 16'h0200);
    send_coefs(16'hfd00, 16'h0001, 16'h7fff);
  endtask

  // Random sets: full range, small and zero leading terms, near-zero discriminants.
  task automatic test_random(input int n);
    logic [15:0] a, b, c;
    for (int i = 0; i < n; i++) begin
      steady = (i >= n / 2) && (i < n / 2 + 200);
      a = 16'($urandom);
      b = 16'($urandom);
      c = 16'($urandom);
      case ($urandom_range(5))
        0: a = 16'($urandom_range(6) - 3);
        1: a = 16'h0000;
        2: begin
          a = 16'($urandom_range(255) + 1);
          c = 16'($urandom_range(255));
          b = $urandom_range(1) ? 16'(2 * (a > c ? c : a)) : -16'(2 * (a > c ? c : a));
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
    steady = 1'b0;
  endtask

  // Long receiver hold-off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    hold_cycles = 300;
    steady = 1'b1;
    for (int i = 0; i < 150; i++) begin
      send_coefs(16'($urandom), 16'($urandom), 16'($urandom));
    end
    steady = 1'b0;
  endtask

  initial begin
    err_cnt      = 0;
    idle_cnt     = 0;
    hold_cycles  = 0;
    steady       = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.coef_a = '0;
    in_if.coef_b = '0;
    in_if.coef_c = '0;
    out_if.ready = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random(1680);
    in_if.valid = 1'b0;
    while (roots_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
